// ===== rtl/midi_event_looper_top_defines.svh =====
// Assertion helpers shared by the looper RTL.
`ifndef MIDI_EVENT_LOOPER_TOP_DEFINES_SVH
`define MIDI_EVENT_LOOPER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mel_pkg.sv =====
package mel_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_STORE_DEPTH = 256;
  localparam int DEF_MAX_BURST   = 16;

  // Request kinds
  localparam logic [3:0] K_TICK    = 4'd0;
  localparam logic [3:0] K_PRESS   = 4'd1;
  localparam logic [3:0] K_ENABLE  = 4'd2;
  localparam logic [3:0] K_DISABLE = 4'd3;
  localparam logic [3:0] K_CLEAR   = 4'd4;
  localparam logic [3:0] K_NOTE    = 4'd5;
  localparam logic [3:0] K_CC      = 4'd6;
  localparam logic [3:0] K_PITCH   = 4'd7;
  localparam logic [3:0] K_STOP    = 4'd8;
  localparam logic [3:0] K_RESTART = 4'd9;

  // Result kinds
  localparam logic [2:0] RK_NOTE_ON  = 3'd0;
  localparam logic [2:0] RK_NOTE_OFF = 3'd1;
  localparam logic [2:0] RK_CC       = 3'd2;
  localparam logic [2:0] RK_BEND     = 3'd3;
  localparam logic [2:0] RK_ALL_OFF  = 3'd4;
  localparam logic [2:0] RK_STATUS   = 3'd5;

  // Looper modes
  localparam logic [2:0] M_OFF   = 3'd0;
  localparam logic [2:0] M_IDLE  = 3'd1;
  localparam logic [2:0] M_REC   = 3'd2;
  localparam logic [2:0] M_PLAY  = 3'd3;
  localparam logic [2:0] M_PAUSE = 3'd4;

  // Stored event types
  localparam logic [1:0] T_ON   = 2'd0;
  localparam logic [1:0] T_OFF  = 2'd1;
  localparam logic [1:0] T_CC   = 2'd2;
  localparam logic [1:0] T_BEND = 2'd3;

  // Config register indexes
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_MAX_EV  = 1'b1;

  localparam logic [15:0] MAX_LEN_RST = 16'd30000;
  localparam logic [8:0]  MAX_EV_RST  = 9'd256;
  localparam logic [16:0] MS_CAP      = 17'h10000;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         data_one;
    logic [7:0]         data_two;
    logic               note_is_on;
    logic signed [15:0] bend_in;
  } item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic [7:0]         out_data_one;
    logic [7:0]         out_data_two;
    logic signed [15:0] out_bend;
    logic [2:0]         mode;
    logic [8:0]         stored_count;
    logic [8:0]         play_position;
    logic [15:0]        loop_length;
    logic [16:0]        elapsed;
    logic               last;
  } result_t;

  // One store entry, 50 bits, timestamp in the low bits
  typedef struct packed {
    logic [15:0] bend;
    logic [7:0]  d2;
    logic [7:0]  d1;
    logic [1:0]  etype;
    logic [15:0] ts;
  } event_t;

endpackage

// ===== rtl/midi_event_looper_top.sv =====
// Channel   Direction  Signals                               Transfer
// request   in         start, busy, item_i                   start && !busy
// result    out        result_valid_o, result_o              one-cycle strobe
// config    in         cfg_we_i, cfg_index_i, cfg_data_i     cfg_we_i
//
// Steps: a plain request runs execute, status, strobe; the next request can be
// accepted while the status strobe is shown. A tick in playback adds a read and
// an event step per event sent, then a read when the take or the burst runs out,
// or a read and an event step when a read finds an event not yet due.
// Reset clears mode and counters and sets config to its defaults; the store contents are not cleared.
// Results cannot be stalled; busy is high from acceptance until status.
`include "midi_event_looper_top_defines.svh"

module midi_event_looper_top #(
  parameter int STORE_DEPTH = mel_pkg::DEF_STORE_DEPTH,
  parameter int MAX_BURST   = mel_pkg::DEF_MAX_BURST
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mel_pkg::item_t  item_i,
  output logic            result_valid_o,
  output mel_pkg::result_t result_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [15:0]     cfg_data_i
);
  import mel_pkg::*;

  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CapW = (CW > 9) ? CW : 9;
  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BW   = $clog2(MAX_BURST + 1);
  localparam int EW   = $bits(event_t);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVT    = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [2:0]    mode_q, mode_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] next_q, next_d;
  logic [15:0]   len_q, len_d;
  logic          lvalid_q, lvalid_d;
  logic [16:0]   rec_ms_q, rec_ms_d;
  logic [16:0]   play_ms_q, play_ms_d;
  logic [BW-1:0] burst_q, burst_d;
  logic [15:0]   max_len_q;
  logic [8:0]    max_ev_q;
  item_t         item_q;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;

  // Event store: one write port, one registered read port
  logic [EW-1:0] store_mem [STORE_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr;
  event_t        wr_evt, rd_evt;

  // Decoded request, valid in S_EXEC
  logic          ready_loop;
  logic          arm;
  logic          rec_eff;
  logic [CW-1:0] total_eff;
  logic [CapW-1:0] cap;
  logic          room;
  logic          late;
  logic          fin_go;
  logic [15:0]   fin_len;
  logic [16:0]   play_inc;

  assign ready_loop = lvalid_q && (len_q != 16'd0) && (total_q != '0);
  assign arm        = (item_q.kind == K_NOTE) && ((mode_q == M_IDLE) || (mode_q == M_PAUSE));
  assign rec_eff    = arm || (mode_q == M_REC);
  assign total_eff  = arm ? '0 : total_q;
  assign cap        = (CapW'(max_ev_q) < CapW'(STORE_DEPTH)) ? CapW'(max_ev_q)
                                                             : CapW'(STORE_DEPTH);
  assign room       = CapW'(total_eff) < cap;
  // when arming, the event time is zero and can never be late
  assign late       = !arm && (rec_ms_q > {1'b0, max_len_q});
  assign fin_len    = (rec_ms_q > {1'b0, max_len_q}) ? max_len_q : rec_ms_q[15:0];
  assign play_inc   = (play_ms_q < MS_CAP) ? play_ms_q + 17'd1 : play_ms_q;
  assign wr_addr    = total_eff[AW-1:0];
  assign rd_evt     = event_t'(rd_data_q);

  always_comb begin
    wr_evt    = '0;
    wr_evt.ts = arm ? 16'd0 : rec_ms_q[15:0];
    unique case (item_q.kind)
      K_NOTE: begin
        wr_evt.etype = item_q.note_is_on ? T_ON : T_OFF;
        wr_evt.d1    = item_q.data_one;
        wr_evt.d2    = item_q.data_two;
      end
      K_CC: begin
        wr_evt.etype = T_CC;
        wr_evt.d1    = item_q.data_one;
        wr_evt.d2    = item_q.data_two;
      end
      default: begin
        wr_evt.etype = T_BEND;
        wr_evt.bend  = item_q.bend_in;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    total_d     = total_q;
    next_d      = next_q;
    len_d       = len_q;
    lvalid_d    = lvalid_q;
    rec_ms_d    = rec_ms_q;
    play_ms_d   = play_ms_q;
    burst_d     = burst_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    fin_go      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_STATUS;
        if (item_q.kind == K_DISABLE) begin
          mode_d            = M_OFF;
          total_d           = '0;
          next_d            = '0;
          len_d             = '0;
          lvalid_d          = 1'b0;
          res_valid_d       = 1'b1;
          res_d.result_kind = RK_ALL_OFF;
        end else if (item_q.kind == K_ENABLE) begin
          if (mode_q == M_OFF) begin
            mode_d = M_IDLE;
          end
        end else if (mode_q != M_OFF) begin
          unique case (item_q.kind)
            K_TICK: begin
              if (mode_q == M_REC) begin
                rec_ms_d = (rec_ms_q < MS_CAP) ? rec_ms_q + 17'd1 : rec_ms_q;
              end else if ((mode_q == M_PLAY) && ready_loop) begin
                // loop wrap drops whatever was still pending
                if (play_inc >= {1'b0, len_q}) begin
                  next_d    = '0;
                  play_ms_d = '0;
                end else begin
                  play_ms_d = play_inc;
                end
                burst_d = '0;
                state_d = S_READ;
              end
            end
            K_PRESS: begin
              priority case (mode_q)
                M_IDLE, M_PAUSE: begin
                  total_d  = '0;
                  next_d   = '0;
                  len_d    = '0;
                  lvalid_d = 1'b0;
                  rec_ms_d = '0;
                  mode_d   = M_REC;
                end
                M_REC:   fin_go = 1'b1;
                M_PLAY:  mode_d = ready_loop ? M_PAUSE : M_IDLE;
                default: ;
              endcase
            end
            K_CLEAR: begin
              total_d  = '0;
              next_d   = '0;
              len_d    = '0;
              lvalid_d = 1'b0;
              mode_d   = M_IDLE;
            end
            K_NOTE, K_CC, K_PITCH: begin
              if (arm) begin
                total_d  = '0;
                next_d   = '0;
                len_d    = '0;
                lvalid_d = 1'b0;
                rec_ms_d = '0;
                mode_d   = M_REC;
              end
              if (rec_eff && room) begin
                if (late) begin
                  fin_go = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  total_d = total_eff + CW'(1);
                end
              end
            end
            K_STOP: begin
              mode_d = ready_loop ? M_PAUSE : M_IDLE;
            end
            K_RESTART: begin
              if (ready_loop) begin
                res_valid_d       = 1'b1;
                res_d.result_kind = RK_ALL_OFF;
                next_d            = '0;
                play_ms_d         = '0;
                mode_d            = M_PLAY;
              end
            end
            default: ;
          endcase

          // end of take: empty time wipes, no events goes idle, else play
          if (fin_go) begin
            if (rec_ms_q == 17'd0) begin
              total_d  = '0;
              next_d   = '0;
              len_d    = '0;
              lvalid_d = 1'b0;
              mode_d   = M_IDLE;
            end else begin
              len_d    = fin_len;
              lvalid_d = (total_q != '0);
              if (total_q != '0) begin
                next_d    = '0;
                play_ms_d = '0;
                mode_d    = M_PLAY;
              end else begin
                mode_d = M_IDLE;
              end
            end
          end
        end
      end

      S_READ: begin
        if ((burst_q < BW'(MAX_BURST)) && (next_q < total_q)) begin
          rd_en   = 1'b1;
          state_d = S_EVT;
        end else begin
          state_d = S_STATUS;
        end
      end

      S_EVT: begin
        if ({1'b0, rd_evt.ts} > play_ms_q) begin
          state_d = S_STATUS;
        end else begin
          res_valid_d = 1'b1;
          unique case (rd_evt.etype)
            T_ON: begin
              res_d.result_kind  = RK_NOTE_ON;
              res_d.out_data_one = rd_evt.d1;
              res_d.out_data_two = rd_evt.d2;
            end
            T_OFF: begin
              res_d.result_kind  = RK_NOTE_OFF;
              res_d.out_data_one = rd_evt.d1;
            end
            T_CC: begin
              res_d.result_kind  = RK_CC;
              res_d.out_data_one = rd_evt.d1;
              res_d.out_data_two = rd_evt.d2;
            end
            default: begin
              res_d.result_kind = RK_BEND;
              res_d.out_bend    = rd_evt.bend;
            end
          endcase
          next_d  = next_q + CW'(1);
          burst_d = burst_q + BW'(1);
          state_d = S_READ;
        end
      end

      S_STATUS: begin
        res_valid_d         = 1'b1;
        res_d.result_kind   = RK_STATUS;
        res_d.mode          = mode_q;
        res_d.stored_count  = 9'(total_q);
        res_d.play_position = 9'(next_q);
        res_d.loop_length   = len_q;
        if ((mode_q == M_PLAY) && (len_q != 16'd0)) begin
          res_d.elapsed = play_ms_q;
        end else if (mode_q == M_REC) begin
          res_d.elapsed = rec_ms_q;
        end
        res_d.last = 1'b1;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_OFF;
      total_q     <= '0;
      next_q      <= '0;
      len_q       <= '0;
      lvalid_q    <= 1'b0;
      rec_ms_q    <= '0;
      play_ms_q   <= '0;
      burst_q     <= '0;
      res_valid_q <= 1'b0;
      max_len_q   <= MAX_LEN_RST;
      max_ev_q    <= MAX_EV_RST;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      total_q     <= total_d;
      next_q      <= next_d;
      len_q       <= len_d;
      lvalid_q    <= lvalid_d;
      rec_ms_q    <= rec_ms_d;
      play_ms_q   <= play_ms_d;
      burst_q     <= burst_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_LEN: max_len_q <= cfg_data_i;
          CFG_MAX_EV:  max_ev_q  <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_evt;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[next_q[AW-1:0]];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `MEL_ASSERT_NXT(a_status_strobe, state_q == S_STATUS, result_valid_o && result_o.last, "status missing after status state")
  `MEL_ASSERT_IMP(a_last_idle, result_valid_o && result_o.last, state_q == S_IDLE, "status while still busy")
  `MEL_ASSERT_IMP(a_next_in_take, 1'b1, next_q <= total_q, "play index beyond take")
  `MEL_ASSERT_IMP(a_burst_cap, 1'b1, burst_q <= BW'(MAX_BURST), "burst count overrun")
  `MEL_ASSERT_IMP(a_off_empty, mode_q == M_OFF, (total_q == '0) && !lvalid_q, "take kept while disabled")

endmodule
